// File: src/rmr_pkg.sv
package rmr_pkg;

  localparam int unsigned InWidth  = 16;
  localparam int unsigned OutWidth = 32;
  localparam int unsigned MagWidth = 2 * InWidth;
  localparam int unsigned CntWidth = $clog2(MagWidth + 1);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StGcd,
    StDivP,
    StDivQ,
    StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic div_sel_q;
    logic div_store;
  } ctrl_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
  } stat_t;

endpackage

// File: src/rmr_if.sv
interface rmr_in_if;
  import rmr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [InWidth-1:0]  num_a;
  logic signed [InWidth-1:0]  den_a;
  logic signed [InWidth-1:0]  num_b;
  logic signed [InWidth-1:0]  den_b;
  modport source (output valid, num_a, den_a, num_b, den_b, input ready);
  modport sink (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rmr_out_if;
  import rmr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OutWidth-1:0] product_num;
  logic signed [OutWidth-1:0] product_den;
  modport source (output valid, product_num, product_den, input ready);
  modport sink (input valid, product_num, product_den, output ready);
endinterface

// File: src/rmr_ctrl.sv
module rmr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rmr_pkg::stat_t stat_i,
  output rmr_pkg::ctrl_t ctrl_o
);
  import rmr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = StMul;
        end
      end
      StMul: begin
        ctrl_o.mul = 1'b1;
        state_d = StGcd;
      end
      StGcd: begin
        if (stat_i.gcd_done) begin
          ctrl_o.div_start = 1'b1;
          state_d = StDivP;
        end else begin
          ctrl_o.gcd_step = 1'b1;
        end
      end
      StDivP: begin
        if (stat_i.div_done) begin
          ctrl_o.div_store = 1'b1;
          ctrl_o.div_start = 1'b1;
          ctrl_o.div_sel_q = 1'b1;
          state_d = StDivQ;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      StDivQ: begin
        ctrl_o.div_sel_q = 1'b1;
        if (stat_i.div_done) begin
          ctrl_o.div_store = 1'b1;
          state_d = StOut;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> ctrl_o.mul)
    else $error("multiply not after load");

endmodule

// File: src/rmr_dp.sv
module rmr_dp (
  input  logic                                  clk_i,
  input  logic signed [rmr_pkg::InWidth-1:0]    num_a_i,
  input  logic signed [rmr_pkg::InWidth-1:0]    den_a_i,
  input  logic signed [rmr_pkg::InWidth-1:0]    num_b_i,
  input  logic signed [rmr_pkg::InWidth-1:0]    den_b_i,
  input  rmr_pkg::ctrl_t                        ctrl_i,
  output rmr_pkg::stat_t                        stat_o,
  output logic signed [rmr_pkg::OutWidth-1:0]   product_num_o,
  output logic signed [rmr_pkg::OutWidth-1:0]   product_den_o
);
  import rmr_pkg::*;

  logic signed [InWidth-1:0]   na_q, da_q, nb_q, db_q;
  logic signed [MagWidth-1:0]  p_q, q_q;
  logic [MagWidth-1:0]         ga_q, gb_q;
  logic [MagWidth-1:0]         rem_q, quo_q, dvd_q;
  logic [CntWidth-1:0]         cnt_q;
  logic [MagWidth:0]           trial;
  logic [MagWidth-1:0]         rem_sh;
  logic                        zero_g;
  logic signed [MagWidth-1:0]  src;
  logic [MagWidth-1:0]         res;
  logic [OutWidth-1:0]         pn_q, pd_q;
  logic                        gstep_div;
  logic signed [MagWidth-1:0]  prod_p, prod_q;
  logic [MagWidth-1:0]         abs_p, abs_q;

  // gcd iterations reuse the shift-subtract divider for the remainder
  assign zero_g     = (ga_q == '0);
  assign src        = (ctrl_i.div_sel_q && !ctrl_i.div_start) ? q_q : p_q;
  assign rem_sh     = {rem_q[MagWidth-2:0], dvd_q[MagWidth-1]};
  assign trial      = {1'b0, rem_sh} - {1'b0, (gstep_div ? gb_q : ga_q)};
  assign gstep_div  = ctrl_i.gcd_step;
  assign stat_o.gcd_done = (gb_q == '0) && (cnt_q == '0);
  assign stat_o.div_done = (cnt_q == '0);
  assign res = src[MagWidth-1] ? -quo_q : quo_q;

  assign prod_p = MagWidth'(na_q) * MagWidth'(nb_q);
  assign prod_q = MagWidth'(da_q) * MagWidth'(db_q);
  assign abs_p  = prod_p[MagWidth-1] ? -prod_p : prod_p;
  assign abs_q  = prod_q[MagWidth-1] ? -prod_q : prod_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      na_q <= num_a_i;
      da_q <= den_a_i;
      nb_q <= num_b_i;
      db_q <= den_b_i;
    end
    if (ctrl_i.mul) begin
      p_q   <= prod_p;
      q_q   <= prod_q;
      ga_q  <= abs_p;
      gb_q  <= abs_q;
      cnt_q <= '0;
    end
    if (ctrl_i.gcd_step) begin
      if (cnt_q == '0) begin
        dvd_q <= ga_q;
        rem_q <= '0;
        cnt_q <= CntWidth'(MagWidth);
      end else begin
        dvd_q <= {dvd_q[MagWidth-2:0], 1'b0};
        if (!trial[MagWidth]) rem_q <= trial[MagWidth-1:0];
        else rem_q <= rem_sh;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntWidth'(1)) begin
          ga_q <= gb_q;
          gb_q <= trial[MagWidth] ? rem_sh : trial[MagWidth-1:0];
        end
      end
    end
    if (ctrl_i.div_start) begin
      dvd_q <= ctrl_i.div_sel_q || !ctrl_i.div_store ? (ctrl_i.div_store ?
               (q_q[MagWidth-1] ? -q_q : q_q) : (p_q[MagWidth-1] ? -p_q : p_q)) :
               (p_q[MagWidth-1] ? -p_q : p_q);
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= zero_g ? '0 : CntWidth'(MagWidth);
    end else if (ctrl_i.div_step) begin
      dvd_q <= {dvd_q[MagWidth-2:0], 1'b0};
      if (!trial[MagWidth]) rem_q <= trial[MagWidth-1:0];
      else rem_q <= rem_sh;
      quo_q <= {quo_q[MagWidth-2:0], ~trial[MagWidth]};
      cnt_q <= cnt_q - 1'b1;
    end
    if (ctrl_i.div_store) begin
      if (ctrl_i.div_sel_q && !ctrl_i.div_start) begin
        pd_q <= zero_g ? q_q[OutWidth-1:0] : res[OutWidth-1:0];
      end else begin
        pn_q <= zero_g ? p_q[OutWidth-1:0] : res[OutWidth-1:0];
      end
    end
  end

  assign product_num_o = pn_q;
  assign product_den_o = pd_q;

endmodule

// File: src/rational_multiply_reduce_unit.sv
// Multiplies two signed 16-bit fractions and returns the product reduced by
// the gcd of numerator and denominator products; signs are kept as formed.
// One transaction at a time, using the shared 32-step shift-subtract divider
// for both the gcd and the final divisions.
module rational_multiply_reduce_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  rmr_in_if.sink   in_i,
  rmr_out_if.source out_o
);
  import rmr_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  rmr_dp u_dp (
    .clk_i         (clk_i),
    .num_a_i       (in_i.num_a),
    .den_a_i       (in_i.den_a),
    .num_b_i       (in_i.num_b),
    .den_b_i       (in_i.den_b),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .product_num_o (out_o.product_num),
    .product_den_o (out_o.product_den)
  );

endmodule
